FILE: rtl/core/assert_macros.svh
// Assertion helpers for the block's RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, reset disables the check.
`define BGC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bgc assertion failed");

// Checked at every rising clock edge, also while reset is asserted.
`define BGC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("bgc assertion failed");

`endif

FILE: rtl/core/bgc_pkg.sv
`default_nettype none
package bgc_pkg;

  localparam int unsigned TimerWidthDef = 16;
  localparam int unsigned CfgW          = 16;

  localparam logic [CfgW-1:0] LongPressReset   = 16'd100;
  localparam logic [CfgW-1:0] DoubleClickReset = 16'd25;

  // register index, taken from paddr[2]
  localparam logic RegLongPress   = 1'b0;
  localparam logic RegDoubleClick = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_HOLD   = 2'd2,
    EV_DOUBLE = 2'd3
  } event_e;

  // status from the click stage
  typedef struct packed {
    logic click_pending;
  } gap_status_t;

endpackage
`default_nettype wire

FILE: rtl/core/bgc_timer.sv
`default_nettype none
// Saturating tick counter; reached_o looks at the value after this tick's increment.
module bgc_timer
  import bgc_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TimerWidthDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            clr_i,
  input  wire logic            inc_i,
  input  wire logic [CfgW-1:0] limit_i,
  output logic                 reached_o
);

  localparam int unsigned CmpW = (TIMER_WIDTH > CfgW) ? TIMER_WIDTH : CfgW;
  localparam logic [TIMER_WIDTH-1:0] TMax = {TIMER_WIDTH{1'b1}};

  logic [TIMER_WIDTH-1:0] count_q, count_d, count_nxt;

  assign count_nxt = (count_q == TMax) ? count_q : count_q + TIMER_WIDTH'(1);
  assign reached_o = (CmpW'(count_nxt) >= CmpW'(limit_i)) || (count_nxt == TMax);

  always_comb begin
    count_d = count_q;
    if (clr_i) begin
      count_d = '0;
    end else if (inc_i) begin
      count_d = count_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/bgc_press.sv
`default_nettype none
// Press stage: debounce, click / hold decision, wait for release.
module bgc_press
  import bgc_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TimerWidthDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic            pin_level_i,
  input  wire logic [CfgW-1:0] long_press_i,
  output event_e               ev_o
);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_CONFIRM = 2'd1,
    PH_TIMING  = 2'd2,
    PH_WAIT    = 2'd3
  } phase_e;

  phase_e phase_q, phase_d;
  logic   low, clr, inc, reached;

  assign low = !pin_level_i;

  always_comb begin
    phase_d = phase_q;
    ev_o    = EV_NONE;
    clr     = 1'b0;
    inc     = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        if (low) begin
          clr     = 1'b1;
          phase_d = PH_CONFIRM;
        end
      end
      PH_CONFIRM: begin
        if (low) begin
          clr     = 1'b1;
          phase_d = PH_TIMING;
        end else begin
          phase_d = PH_IDLE;
        end
      end
      PH_TIMING: begin
        if (!low) begin
          ev_o    = EV_SINGLE;
          phase_d = PH_IDLE;
        end else begin
          inc = 1'b1;
          if (reached) begin
            ev_o    = EV_HOLD;
            phase_d = PH_WAIT;
          end
        end
      end
      PH_WAIT: begin
        if (!low) begin
          phase_d = PH_IDLE;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  bgc_timer #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_press_timer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (step_i && clr),
    .inc_i    (step_i && inc),
    .limit_i  (long_press_i),
    .reached_o(reached)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else if (step_i) begin
      phase_q <= phase_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/bgc_gap.sv
`default_nettype none
// Click stage: holds a click back for the double-click window.
module bgc_gap
  import bgc_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TimerWidthDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire event_e          ev_i,
  input  wire logic [CfgW-1:0] double_click_i,
  output event_e               res_o,
  output gap_status_t          status_o
);

  logic pending_q, pending_d, clr, inc, reached;

  always_comb begin
    pending_d = pending_q;
    res_o     = EV_NONE;
    clr       = 1'b0;
    inc       = 1'b0;
    if (!pending_q) begin
      if (ev_i == EV_SINGLE) begin
        clr       = 1'b1;
        pending_d = 1'b1;
      end else begin
        res_o = ev_i;
      end
    end else if (ev_i == EV_SINGLE) begin
      res_o     = EV_DOUBLE;
      pending_d = 1'b0;
    end else begin
      // a hold in the window is dropped; the window keeps running
      inc = 1'b1;
      if (reached) begin
        res_o     = EV_SINGLE;
        pending_d = 1'b0;
      end
    end
  end

  bgc_timer #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_gap_timer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (step_i && clr),
    .inc_i    (step_i && inc),
    .limit_i  (double_click_i),
    .reached_o(reached)
  );

  assign status_o.click_pending = pending_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else if (step_i) begin
      pending_q <= pending_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/button_gesture_classifier.sv
// Button gesture classifier.
// Input stream: one word per tick, tdata[0] = pin level (0 pressed, 1 released).
// Output stream: one word per input word, tdata[1:0] = event code
//   (none, single click, long hold, double click).
// APB port: register 0 at 0x0 long-press ticks, register 1 at 0x4
//   double-click ticks; pready is tied high, writes land in the access cycle.
// The event for an accepted word is registered into the output register, or into the
//   skid word if the output stalls. Throughput: one word per cycle while the skid is
//   empty, set by the single state update of the press and click stages per word.
// Stall: a two-deep output buffer (output register plus skid) keeps taking
//   words while one result waits; s_axis_tready drops only when both are full.
// Reset (rst_ni low, async): both stages idle, timers zero, no pending click,
//   output buffer empty, registers back to 100 and 25 ticks.
// A gap ends on the limit or on timer saturation; a limit of 0 acts as 1.
`default_nettype none
`include "assert_macros.svh"
module button_gesture_classifier
  import bgc_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TimerWidthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] pin_level, [7:1] zero
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [1:0] event_code, [7:2] zero
  // APB configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // config registers
  logic [CfgW-1:0] long_press_q, double_click_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q   <= LongPressReset;
      double_click_q <= DoubleClickReset;
    end else if (cfg_wr) begin
      if (paddr[2] == RegLongPress) begin
        long_press_q <= pwdata[CfgW-1:0];
      end else begin
        double_click_q <= pwdata[CfgW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == RegLongPress) begin
      prdata = 32'(long_press_q);
    end else begin
      prdata = 32'(double_click_q);
    end
  end

  // stages
  logic        accept;
  event_e      ev, res;
  gap_status_t gap_status;

  assign accept = s_axis_tvalid && s_axis_tready;

  bgc_press #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_press (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .pin_level_i (s_axis_tdata[0]),
    .long_press_i(long_press_q),
    .ev_o        (ev)
  );

  bgc_gap #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_gap (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (accept),
    .ev_i          (ev),
    .double_click_i(double_click_q),
    .res_o         (res),
    .status_o      (gap_status)
  );

  // output register plus skid word
  logic   out_valid_q, out_valid_d, skid_valid_q, skid_valid_d, pop;
  event_e out_data_q, out_data_d, skid_data_q, skid_data_d;

  assign pop           = out_valid_q && m_axis_tready;
  assign s_axis_tready = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || pop) begin
      // output slot free: drain skid first, else take the new word
      out_valid_d  = skid_valid_q || accept;
      out_data_d   = skid_valid_q ? skid_data_q : res;
      skid_valid_d = 1'b0;
    end else if (accept) begin
      skid_valid_d = 1'b1;
      skid_data_d  = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_data_q};

  // checks
  `BGC_ASSERT_ALWAYS(a_skid_needs_out, clk_i, skid_valid_q |-> out_valid_q)
  `BGC_ASSERT(a_stall_fills_skid, clk_i, rst_ni,
              accept && out_valid_q && !m_axis_tready |=> skid_valid_q)
  `BGC_ASSERT(a_double_needs_pending, clk_i, rst_ni,
              accept && (res == EV_DOUBLE) |-> gap_status.click_pending)

endmodule
`default_nettype wire
